// ===== hw/rtl/tdpt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tdpt_pkg;

  // branch conditions of the control store
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_LE1,
    C_LE3,
    C_EVEN,
    C_DIV_BUSY,
    C_REM_ZERO,
    C_D_GT_Q,
    C_OUT_BUSY
  } cond_e;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_DIV3,
    OP_SET_D5,
    OP_DIV_D,
    OP_DIV_D2,
    OP_ADD6,
    OP_RES0,
    OP_RES1
  } op_e;

  localparam int unsigned PcW = 5;

  typedef logic [PcW-1:0] pc_t;

  typedef struct packed {
    cond_e cond;
    pc_t   target;
    op_e   op;
  } ctrl_word_t;

  // step addresses
  localparam pc_t StepIdle    = pc_t'(0);
  localparam pc_t StepLe1     = pc_t'(1);
  localparam pc_t StepLe3     = pc_t'(2);
  localparam pc_t StepEven    = pc_t'(3);
  localparam pc_t StepDiv3    = pc_t'(4);
  localparam pc_t StepWait3   = pc_t'(5);
  localparam pc_t StepChk3    = pc_t'(6);
  localparam pc_t StepInitD   = pc_t'(7);
  localparam pc_t StepDivD    = pc_t'(8);
  localparam pc_t StepWaitD   = pc_t'(9);
  localparam pc_t StepBound   = pc_t'(10);
  localparam pc_t StepChkD    = pc_t'(11);
  localparam pc_t StepDivD2   = pc_t'(12);
  localparam pc_t StepWaitD2  = pc_t'(13);
  localparam pc_t StepChkD2   = pc_t'(14);
  localparam pc_t StepNextD   = pc_t'(15);
  localparam pc_t StepRes0    = pc_t'(16);
  localparam pc_t StepRes0Ret = pc_t'(17);
  localparam pc_t StepRes1    = pc_t'(18);
  localparam pc_t StepRes1Ret = pc_t'(19);

  // control store: jump to target when the condition holds, else fall through
  function automatic ctrl_word_t rom_word(pc_t pc);
    ctrl_word_t w;
    w = '{cond: C_ALWAYS, target: StepIdle, op: OP_NONE};
    unique case (pc)
      StepIdle:    w = '{cond: C_NO_INPUT, target: StepIdle,    op: OP_ACCEPT};
      StepLe1:     w = '{cond: C_LE1,      target: StepRes0,    op: OP_NONE};
      StepLe3:     w = '{cond: C_LE3,      target: StepRes1,    op: OP_NONE};
      StepEven:    w = '{cond: C_EVEN,     target: StepRes0,    op: OP_NONE};
      StepDiv3:    w = '{cond: C_NEVER,    target: StepIdle,    op: OP_DIV3};
      StepWait3:   w = '{cond: C_DIV_BUSY, target: StepWait3,   op: OP_NONE};
      StepChk3:    w = '{cond: C_REM_ZERO, target: StepRes0,    op: OP_NONE};
      StepInitD:   w = '{cond: C_NEVER,    target: StepIdle,    op: OP_SET_D5};
      StepDivD:    w = '{cond: C_NEVER,    target: StepIdle,    op: OP_DIV_D};
      StepWaitD:   w = '{cond: C_DIV_BUSY, target: StepWaitD,   op: OP_NONE};
      StepBound:   w = '{cond: C_D_GT_Q,   target: StepRes1,    op: OP_NONE};
      StepChkD:    w = '{cond: C_REM_ZERO, target: StepRes0,    op: OP_NONE};
      StepDivD2:   w = '{cond: C_NEVER,    target: StepIdle,    op: OP_DIV_D2};
      StepWaitD2:  w = '{cond: C_DIV_BUSY, target: StepWaitD2,  op: OP_NONE};
      StepChkD2:   w = '{cond: C_REM_ZERO, target: StepRes0,    op: OP_NONE};
      StepNextD:   w = '{cond: C_ALWAYS,   target: StepDivD,    op: OP_ADD6};
      StepRes0:    w = '{cond: C_OUT_BUSY, target: StepRes0,    op: OP_RES0};
      StepRes0Ret: w = '{cond: C_ALWAYS,   target: StepIdle,    op: OP_NONE};
      StepRes1:    w = '{cond: C_OUT_BUSY, target: StepRes1,    op: OP_RES1};
      StepRes1Ret: w = '{cond: C_ALWAYS,   target: StepIdle,    op: OP_NONE};
      default:     w = '{cond: C_ALWAYS,   target: StepIdle,    op: OP_NONE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tdpt_cand_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tdpt_cand_if #(
  parameter int unsigned W = 32
);
  logic         valid;
  logic         ready;
  logic [W-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tdpt_flag_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tdpt_flag_if;
  logic valid;
  logic ready;
  logic prime_flag;

  modport source (output valid, output prime_flag, input ready);
  modport sink   (input valid, input prime_flag, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/trial_division_prime_test.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel  | dir | payload                  | transaction
// ---------+-----+--------------------------+----------------------------
// cand_i   | in  | candidate [NUM_WIDTH]    | one number to test
// flag_o   | out | prime_flag [1]           | one verdict per candidate
//
// small numbers and multiples of two skip the divider; others take a division
//   by three, plus up to two divisions per divisor pair, for about sqrt(n) / 6 pairs
// the loop is set by one shared bit-serial restoring divider (one quotient bit
//   per cycle)
// reset clears the step counter, divider counter and output valid only
// one candidate is worked on at a time; the next one is taken while the
//   previous verdict still waits in the output register

module trial_division_prime_test #(
  parameter int unsigned NUM_WIDTH = 32
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  tdpt_cand_if.sink      cand_i,
  tdpt_flag_if.source    flag_o
);

  localparam int unsigned W    = NUM_WIDTH;
  localparam int unsigned CntW = $clog2(W + 1);

  // sequencer
  tdpt_pkg::pc_t        pc_q, pc_d;
  tdpt_pkg::ctrl_word_t cw;
  logic                 cond_true;

  // datapath registers
  logic [W-1:0]    n_q, n_d;      // candidate under test
  logic [W-1:0]    d_q, d_d;      // current 6k-1 divisor
  logic [W-1:0]    dv_q, dv_d;    // divisor fed to the divider
  logic [W-1:0]    rem_q, rem_d;  // partial remainder
  logic [W-1:0]    quo_q, quo_d;  // dividend shifting out, quotient shifting in
  logic [CntW-1:0] cnt_q, cnt_d;  // divider bits left

  logic            out_valid_q, out_valid_d;
  logic            out_flag_q, out_flag_d;

  // divider step
  logic [W:0]      trial;
  logic            ge;
  logic [W:0]      diff;

  logic            div_busy;
  logic            out_busy;
  logic            accept;

  assign cw       = tdpt_pkg::rom_word(pc_q);
  assign div_busy = (cnt_q != '0);
  assign out_busy = out_valid_q && !flag_o.ready;

  assign cand_i.ready     = (cw.op == tdpt_pkg::OP_ACCEPT);
  assign accept           = cand_i.valid && cand_i.ready;
  assign flag_o.valid     = out_valid_q;
  assign flag_o.prime_flag = out_flag_q;

  // branch condition select
  always_comb begin
    unique case (cw.cond)
      tdpt_pkg::C_NEVER:    cond_true = 1'b0;
      tdpt_pkg::C_ALWAYS:   cond_true = 1'b1;
      tdpt_pkg::C_NO_INPUT: cond_true = !cand_i.valid;
      tdpt_pkg::C_LE1:      cond_true = (n_q[W-1:1] == '0);
      tdpt_pkg::C_LE3:      cond_true = (n_q[W-1:2] == '0);
      tdpt_pkg::C_EVEN:     cond_true = !n_q[0];
      tdpt_pkg::C_DIV_BUSY: cond_true = div_busy;
      tdpt_pkg::C_REM_ZERO: cond_true = (rem_q == '0);
      tdpt_pkg::C_D_GT_Q:   cond_true = (d_q > quo_q);
      tdpt_pkg::C_OUT_BUSY: cond_true = out_busy;
      default:              cond_true = 1'b1;
    endcase
  end

  // next step
  always_comb begin
    pc_d = cond_true ? cw.target : pc_q + tdpt_pkg::pc_t'(1);
  end

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem_q, quo_q[W-1]};
    ge    = (trial >= {1'b0, dv_q});
    diff  = trial - {1'b0, dv_q};
  end

  // datapath controls
  always_comb begin
    n_d  = n_q;
    d_d  = d_q;
    dv_d = dv_q;
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;

    if (div_busy) begin
      rem_d = ge ? diff[W-1:0] : trial[W-1:0];
      quo_d = {quo_q[W-2:0], ge};
      cnt_d = cnt_q - CntW'(1);
    end

    unique case (cw.op)
      tdpt_pkg::OP_ACCEPT: begin
        if (accept) begin
          n_d = cand_i.candidate;
        end
      end
      tdpt_pkg::OP_DIV3: begin
        dv_d  = W'(3);
        rem_d = '0;
        quo_d = n_q;
        cnt_d = CntW'(W);
      end
      tdpt_pkg::OP_SET_D5: begin
        d_d = W'(5);
      end
      tdpt_pkg::OP_DIV_D: begin
        dv_d  = d_q;
        rem_d = '0;
        quo_d = n_q;
        cnt_d = CntW'(W);
      end
      tdpt_pkg::OP_DIV_D2: begin
        dv_d  = d_q + W'(2);
        rem_d = '0;
        quo_d = n_q;
        cnt_d = CntW'(W);
      end
      tdpt_pkg::OP_ADD6: begin
        d_d = d_q + W'(6);
      end
      default: begin
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_flag_d  = out_flag_q;
    if (out_valid_q && flag_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (!out_busy) begin
      if (cw.op == tdpt_pkg::OP_RES0) begin
        out_valid_d = 1'b1;
        out_flag_d  = 1'b0;
      end else if (cw.op == tdpt_pkg::OP_RES1) begin
        out_valid_d = 1'b1;
        out_flag_d  = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= tdpt_pkg::StepIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    d_q        <= d_d;
    dv_q       <= dv_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    out_flag_q <= out_flag_d;
  end

  // divider never counts past the word width
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(W))
    else $error("divider bit counter out of range");

  // an accepted candidate always goes to the first range check
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> pc_q == tdpt_pkg::StepLe1)
    else $error("sequencer did not start after accept");

  // a new verdict only comes from a result step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |->
      ($past(pc_q) == tdpt_pkg::StepRes0 || $past(pc_q) == tdpt_pkg::StepRes1))
    else $error("verdict raised outside a result step");

  // while the divider runs the sequencer sits on a wait step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |->
      (pc_q == tdpt_pkg::StepWait3 || pc_q == tdpt_pkg::StepWaitD ||
       pc_q == tdpt_pkg::StepWaitD2))
    else $error("divider busy outside a wait step");

  // a finished division leaves a remainder below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 && $past(cnt_q) == CntW'(1)) |-> rem_q < dv_q)
    else $error("divider remainder not reduced");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps

// checks trial_division_prime_test against its own verdict computation
// candidates are recorded when their transaction is accepted
// each verdict transaction is compared with the oldest recorded candidate

module tb;

  localparam int unsigned NumW       = 32;
  // quiet cycles allowed before giving up
  localparam int unsigned QuietLimit = 100000;
  localparam int unsigned RandCount  = 75;
  localparam int unsigned SettleCyc  = 20;

  // verdict bookkeeping: candidates in flight and their predicted answers
  class verdict_board;
    logic [NumW-1:0] cand_q[$];
    bit              verdict_q[$];
    int unsigned     errors;

    function new();
      errors = 0;
    endfunction

    // straight trial division by 2, 3, then the 6k-1 / 6k+1 pairs
    function bit prime_by_division(longint unsigned n);
      longint unsigned d;
      if (n <= 1) return 1'b0;
      if (n <= 3) return 1'b1;
      if ((n % 2) == 0 || (n % 3) == 0) return 1'b0;
      for (d = 5; d <= n / d; d += 6) begin
        if ((n % d) == 0 || (n % (d + 2)) == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function void note_candidate(logic [NumW-1:0] cand);
      longint unsigned n;
      // anything above the configured width is dropped by the block
      n = 64'(cand) & ((64'd1 << NumW) - 64'd1);
      cand_q.push_back(cand);
      verdict_q.push_back(prime_by_division(n));
    endfunction

    task check_verdict(logic flag);
      logic [NumW-1:0] cand;
      bit              want;
      if (verdict_q.size() == 0) begin
        report($sformatf("verdict %b arrived with no candidate outstanding", flag));
      end else begin
        cand = cand_q.pop_front();
        want = verdict_q.pop_front();
        if (flag !== want)
          report($sformatf("candidate %0d: prime_flag %b, expected %b", cand, flag, want));
      end
    endtask

    function int unsigned pending();
      return verdict_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  tdpt_cand_if #(.W(NumW)) cand_if ();
  tdpt_flag_if             flag_if ();

  trial_division_prime_test #(
    .NUM_WIDTH(NumW)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cand_i(cand_if),
    .flag_o(flag_if)
  );

  verdict_board board;
  // no random idling on either side while this is set
  bit           calm;
  int unsigned  quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // sender side: optional burst of idle cycles before the next candidate
  task automatic sender_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      cand_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  // present one candidate and hold it until the transaction completes
  // valid stays high afterwards so back-to-back candidates need no toggle
  task automatic send_candidate(input logic [NumW-1:0] cand);
    sender_gap();
    cand_if.valid     <= 1'b1;
    cand_if.candidate <= cand;
    do @(posedge clk_i); while (!cand_if.ready);
  endtask

  // stop sending and wait until every outstanding verdict is back
  task automatic drain_verdicts();
    cand_if.valid <= 1'b0;
    // wait so the monitor has recorded the last accepted candidate
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // random candidates, mostly small so the divider loop stays short;
  // wide ones carry a small known factor, which ends the search early
  function automatic logic [NumW-1:0] pick_candidate();
    int unsigned sel;
    int unsigned factor;
    int unsigned mult;
    int unsigned small_primes[8] = '{3, 5, 7, 11, 13, 17, 19, 23};
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      return NumW'($urandom_range(0, 4095));
    end else if (sel < 75) begin
      return NumW'($urandom_range(4096, 65535));
    end else if (sel < 85) begin
      // wide even number
      return NumW'($urandom) & ~NumW'(1);
    end else begin
      factor = small_primes[$urandom_range(0, 7)];
      mult   = $urandom_range(1, 32'hFFFF_FFFF / factor);
      return NumW'(mult * factor);
    end
  endfunction

  // receiver side: ready mostly high, dropped in bursts while not calm
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        flag_if.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
      flag_if.ready <= 1'b1;
    end
  end

  // transaction monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cand_if.valid && cand_if.ready) board.note_candidate(cand_if.candidate);
      if (flag_if.valid && flag_if.ready) board.check_verdict(flag_if.prime_flag);
      if ((cand_if.valid && cand_if.ready) || (flag_if.valid && flag_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
          $display("timeout after %0d cycles without a transaction", quiet_cycles);
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  initial begin
    // directed candidates: trivial values, small primes and composites,
    // exact squares at the loop bound, hits on either divisor of a pair,
    // wide values at the extremes of the field
    logic [NumW-1:0] directed[$] = '{
      0, 1, 2, 3, 4, 5, 6, 7, 9, 25, 29, 35, 49, 77, 121, 143, 169,
      65521, 65537, 1018081, 1000003,
      32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h5555_5555
    };

    cand_if.valid     = 1'b0;
    cand_if.candidate = '0;
    flag_if.ready     = 1'b0;
    rst_ni            = 1'b0;
    calm              = 1'b0;
    quiet_cycles      = 0;
    board             = new();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_candidate(directed[i]);

    // let the pipeline run dry before the random part
    drain_verdicts();

    for (int i = 0; i < RandCount; i++) begin
      // a calm stretch in the middle and a calm tail at the end
      calm = (i >= 25 && i < 35) || (i >= RandCount - 20);
      send_candidate(pick_candidate());
    end

    drain_verdicts();
    // keep clocking so a stray extra verdict would still be caught
    repeat (SettleCyc) @(posedge clk_i);

    if (board.errors == 0 && board.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
